// ===== hw/rtl/ffb_pkg.sv =====
// Shared constants and CRC helpers for the fixed frame builder.
// No dependencies; used by the interfaces, the top level and the testbench.
package ffb_pkg;

	localparam int unsigned DATA_FIELD_BYTES = 300;
	localparam int unsigned FRAME_BYTES      = DATA_FIELD_BYTES + 9;
	localparam int unsigned POS_W            = $clog2(FRAME_BYTES);
	localparam int unsigned LEN_W            = 9;
	localparam int unsigned PADDR_W          = 3;

	localparam logic [7:0]  SOF_BYTE    = 8'hA5;
	localparam logic [7:0]  CRC8_POLY   = 8'h8C;
	localparam logic [7:0]  CRC8_INIT   = 8'hFF;
	localparam logic [15:0] CRC16_POLY  = 16'h8408;
	localparam logic [15:0] CRC16_INIT  = 16'hFFFF;
	localparam logic [15:0] CMD_ID_RST  = 16'h0310;

	localparam logic [15:0] FIELD_LEN   = 16'(DATA_FIELD_BYTES);
	localparam logic [LEN_W-1:0] FIELD_LEN_L = LEN_W'(DATA_FIELD_BYTES);

	// frame positions
	localparam logic [POS_W-1:0] POS_SOF     = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_SEQ     = POS_W'(3);
	localparam logic [POS_W-1:0] POS_HCRC    = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CMD_LO  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_CMD_HI  = POS_W'(6);
	localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(7);
	localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_CRC_HI  = POS_W'(FRAME_BYTES - 1);

	// register index
	localparam logic REG_COMMAND_ID = 1'b0;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// header CRC over SOF and the fixed length; only the sequence byte varies
	localparam logic [7:0] HCRC_PRE =
		crc8_byte(crc8_byte(crc8_byte(CRC8_INIT, SOF_BYTE), FIELD_LEN[7:0]), FIELD_LEN[15:8]);

endpackage

// ===== hw/rtl/ffb_if.sv =====
// Valid/ready channel interfaces for the fixed frame builder.
// Depends on ffb_pkg for field widths.
interface ffb_in_if;
	logic                       valid;
	logic                       ready;
	logic [7:0]                 payload_byte;
	logic [ffb_pkg::LEN_W-1:0]  payload_length;

	modport source(output valid, output payload_byte, output payload_length, input ready);
	modport sink(input valid, input payload_byte, input payload_length, output ready);
endinterface

interface ffb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       byte_taken;
	logic       frame_end;
	logic       rejected;

	modport source(output valid, output frame_byte, output byte_taken, output frame_end,
		output rejected, input ready);
	modport sink(input valid, input frame_byte, input byte_taken, input frame_end,
		input rejected, output ready);
endinterface

// ===== hw/rtl/fixed_frame_builder_crc8_crc16.sv =====
// Fixed frame builder: one frame byte per accepted tick, header CRC-8, frame CRC-16.
// Pipeline: input register (s1), then result register; the byte-wide CRC-16 update
// sits between them. Throughput: one item per cycle unless the output stalls.
// Reset (arst_n low, async): frame position 0, sequence 0, CRC 0xFFFF, command id 0x0310,
// both stages empty.
// Depends on ffb_pkg and ffb_if.
module fixed_frame_builder_crc8_crc16 (
	input  logic                        clk,
	input  logic                        arst_n,
	ffb_in_if.sink                      payload,
	ffb_out_if.source                   frame,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ffb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       byte_taken;
		logic       frame_end;
		logic       rejected;
	} result_t;

	// configuration register
	logic [15:0] command_id_q;

	// input stage
	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic [ffb_pkg::LEN_W-1:0]  length_s1;

	// framing state
	logic [ffb_pkg::POS_W-1:0]  pos_q;
	logic [7:0]                 seq_q;
	logic [15:0]                crc_q;
	logic [ffb_pkg::LEN_W-1:0]  len_q;

	// result stage
	logic    out_valid_q;
	result_t res_q;

	logic    advance;
	logic    accept;
	result_t res_d;
	logic    reject_d;
	logic [15:0] crc_base;
	logic [ffb_pkg::POS_W-1:0] pay_idx;

	// APB: no wait states (pready tied high); reads return the register, zero elsewhere
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ffb_pkg::REG_COMMAND_ID) ? {16'h0000, command_id_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_id_q <= ffb_pkg::CMD_ID_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == ffb_pkg::REG_COMMAND_ID) begin
			command_id_q <= pwdata[15:0];
		end
	end

	// Advance s1 into the result register whenever the result slot is free or being taken.
	assign advance       = valid_s1 && (!out_valid_q || frame.ready);
	assign payload.ready = !valid_s1 || advance;
	assign accept        = payload.valid && payload.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.ready) begin
			valid_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1   <= payload.payload_byte;
			length_s1 <= payload.payload_length;
		end
	end

	// Frame byte selection for the item in s1.
	assign reject_d = (pos_q == ffb_pkg::POS_SOF) && (length_s1 > ffb_pkg::FIELD_LEN_L);
	assign pay_idx  = pos_q - ffb_pkg::POS_PAYLOAD;

	always_comb begin
		res_d = '0;
		case (pos_q)
			ffb_pkg::POS_SOF:    res_d.frame_byte = ffb_pkg::SOF_BYTE;
			ffb_pkg::POS_LEN_LO: res_d.frame_byte = ffb_pkg::FIELD_LEN[7:0];
			ffb_pkg::POS_LEN_HI: res_d.frame_byte = ffb_pkg::FIELD_LEN[15:8];
			ffb_pkg::POS_SEQ:    res_d.frame_byte = seq_q;
			ffb_pkg::POS_HCRC:   res_d.frame_byte = ffb_pkg::crc8_byte(ffb_pkg::HCRC_PRE, seq_q);
			ffb_pkg::POS_CMD_LO: res_d.frame_byte = command_id_q[7:0];
			ffb_pkg::POS_CMD_HI: res_d.frame_byte = command_id_q[15:8];
			ffb_pkg::POS_CRC_LO: res_d.frame_byte = crc_q[7:0];
			ffb_pkg::POS_CRC_HI: begin
				res_d.frame_byte = crc_q[15:8];
				res_d.frame_end  = 1'b1;
			end
			default: begin
				// data field: payload until the latched length, then zero padding
				if (pay_idx < ffb_pkg::POS_W'(len_q)) begin
					res_d.frame_byte = byte_s1;
					res_d.byte_taken = 1'b1;
				end
			end
		endcase
		if (reject_d) begin
			res_d          = '0;
			res_d.rejected = 1'b1;
		end
	end

	// CRC-16 restarts at the SOF byte
	assign crc_base = (pos_q == ffb_pkg::POS_SOF) ? ffb_pkg::CRC16_INIT : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= ffb_pkg::POS_SOF;
			seq_q <= 8'h00;
			crc_q <= ffb_pkg::CRC16_INIT;
			len_q <= '0;
		end else if (advance && !reject_d) begin
			if (pos_q == ffb_pkg::POS_SOF) begin
				len_q <= length_s1;
			end
			if (pos_q == ffb_pkg::POS_CRC_HI) begin
				// close the frame: wrap position, bump sequence
				pos_q <= ffb_pkg::POS_SOF;
				seq_q <= seq_q + 8'h01;
				crc_q <= ffb_pkg::CRC16_INIT;
			end else begin
				pos_q <= pos_q + ffb_pkg::POS_W'(1);
				if (pos_q != ffb_pkg::POS_CRC_LO) begin
					crc_q <= ffb_pkg::crc16_byte(crc_base, res_d.frame_byte);
				end
			end
		end
	end

	// Result register: hold while stalled, load on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || frame.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = res_q.frame_byte;
	assign frame.byte_taken = res_q.byte_taken;
	assign frame.frame_end  = res_q.frame_end;
	assign frame.rejected   = res_q.rejected;

endmodule

// ===== hw/rtl/ffb_checker.sv =====
// Port-level checks for the fixed frame builder, bound to the top level.
// Depends on the top level's channel interfaces through the bind below.
module ffb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic       byte_taken,
	input logic       frame_end,
	input logic       rejected
);

	// a rejected tick carries nothing else
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> frame_byte == 8'h00 && !byte_taken && !frame_end)
		else $error("rejected result carries frame data");

	// the last CRC byte is never a payload byte or a reject
	a_end_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> !byte_taken && !rejected)
		else $error("frame end combined with payload or reject");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(rejected))
		else $error("stalled result changed");

	// a fresh result comes from an item accepted through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching item");

endmodule

bind fixed_frame_builder_crc8_crc16 ffb_checker u_ffb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (payload.valid),
	.in_ready   (payload.ready),
	.out_valid  (frame.valid),
	.out_ready  (frame.ready),
	.frame_byte (frame.frame_byte),
	.byte_taken (frame.byte_taken),
	.frame_end  (frame.frame_end),
	.rejected   (frame.rejected)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for fixed_frame_builder_crc8_crc16: pulls frame bytes tick by tick
// and compares each one against an in-bench frame predictor. Needs ffb_pkg and ffb_if.
module tb;

	localparam logic [ffb_pkg::PADDR_W-1:0] ADDR_COMMAND_ID =
		ffb_pkg::PADDR_W'(4 * int'(ffb_pkg::REG_COMMAND_ID));
	// next register slot: no register lives there, writes must be dropped
	localparam logic [ffb_pkg::PADDR_W-1:0] ADDR_UNMAPPED =
		ADDR_COMMAND_ID + ffb_pkg::PADDR_W'(4);
	localparam int unsigned        CYCLE_LIMIT     = 200000;
	localparam int unsigned        MAX_IDLE        = 10;
	localparam int unsigned        DRAIN_CYCLES    = 8;

	// one expected frame byte and its flags
	typedef struct packed {
		logic [7:0] data_byte;
		logic       taken;
		logic       frame_last;
		logic       reject;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [ffb_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	ffb_in_if  pay_if ();
	ffb_out_if frm_if ();

	fixed_frame_builder_crc8_crc16 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (pay_if),
		.frame   (frm_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Frame predictor state: position in frame, sequence, running CRC-16,
	// latched payload length and the command id register.
	int unsigned fb_pos;
	logic [7:0]  fb_seq;
	logic [15:0] fb_crc;
	logic [8:0]  fb_len;
	logic [15:0] fb_cmd;

	frame_byte_t pending_bytes[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// idling controls for the sender (src_idle) and the receiver (sink_*)
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;
	int unsigned sink_hold_req = 0;
	int unsigned sink_hold = 0;
	int unsigned sink_wait = 0;

	// Reflected CRC-8, poly 0x8C, one data bit at a time, LSB first.
	function automatic logic [7:0] hdr_crc_step(input logic [7:0] c, input logic [7:0] d);
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i]) begin
				c = (c >> 1) ^ ffb_pkg::CRC8_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Reflected CRC-16 (MCRF4XX), poly 0x8408, one data bit at a time, LSB first.
	function automatic logic [15:0] frame_crc_step(input logic [15:0] c, input logic [7:0] d);
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i]) begin
				c = (c >> 1) ^ ffb_pkg::CRC16_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Work out the byte the block emits for one tick and advance the frame state.
	function automatic frame_byte_t build_next_byte(input logic [7:0] pb, input logic [8:0] plen);
		frame_byte_t r;
		logic [7:0]  hc;
		int unsigned p;
		r = '0;
		p = (fb_pos >= ffb_pkg::FRAME_BYTES) ? 0 : fb_pos;
		if (p == 0) begin
			// oversize length on the first tick: flag it and stay at frame start
			if (plen > ffb_pkg::DATA_FIELD_BYTES) begin
				r.reject = 1'b1;
				fb_pos = 0;
				return r;
			end
			fb_len = plen;
			fb_crc = ffb_pkg::CRC16_INIT;
			r.data_byte = ffb_pkg::SOF_BYTE;
		end else if (p == 1) begin
			r.data_byte = ffb_pkg::FIELD_LEN[7:0];
		end else if (p == 2) begin
			r.data_byte = ffb_pkg::FIELD_LEN[15:8];
		end else if (p == 3) begin
			r.data_byte = fb_seq;
		end else if (p == 4) begin
			hc = hdr_crc_step(ffb_pkg::CRC8_INIT, ffb_pkg::SOF_BYTE);
			hc = hdr_crc_step(hc, ffb_pkg::FIELD_LEN[7:0]);
			hc = hdr_crc_step(hc, ffb_pkg::FIELD_LEN[15:8]);
			r.data_byte = hdr_crc_step(hc, fb_seq);
		end else if (p == 5) begin
			r.data_byte = fb_cmd[7:0];
		end else if (p == 6) begin
			r.data_byte = fb_cmd[15:8];
		end else if (p < ffb_pkg::FRAME_BYTES - 2) begin
			// payload bytes until the latched length is used up, zero padding after
			if (p - 7 < fb_len) begin
				r.data_byte = pb;
				r.taken = 1'b1;
			end
		end else if (p == ffb_pkg::FRAME_BYTES - 2) begin
			r.data_byte = fb_crc[7:0];
		end else begin
			r.data_byte = fb_crc[15:8];
			r.frame_last = 1'b1;
		end

		if (p < ffb_pkg::FRAME_BYTES - 2) begin
			fb_crc = frame_crc_step(fb_crc, r.data_byte);
		end

		if (r.frame_last) begin
			fb_pos = 0;
			fb_seq = fb_seq + 8'd1;
			fb_crc = ffb_pkg::CRC16_INIT;
		end else begin
			fb_pos = p + 1;
		end
		return r;
	endfunction

	// Offer one tick to the block and record its expected byte once accepted.
	// Valid stays high into the next call when no gap is drawn.
	task automatic send_tick(input logic [7:0] pb, input logic [8:0] plen);
		int unsigned gap;
		frame_byte_t exp_byte;
		gap = src_idle ? $urandom_range(MAX_IDLE, 0) : 0;
		if (gap != 0) begin
			pay_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pay_if.valid          <= 1'b1;
		pay_if.payload_byte   <= pb;
		pay_if.payload_length <= plen;
		do @(posedge clk); while (!pay_if.ready);
		exp_byte = build_next_byte(pb, plen);
		pending_bytes = {pending_bytes, exp_byte};
	endtask

	// Random tick: at frame start pick a length (sometimes oversize),
	// elsewhere the length field is noise the block must ignore.
	task automatic send_random_tick();
		logic [8:0] len;
		if (fb_pos == 0) begin
			case ($urandom_range(5, 0))
				0: len = 9'($urandom_range(511, ffb_pkg::DATA_FIELD_BYTES + 1));
				1: len = 9'd0;
				2: len = 9'(ffb_pkg::DATA_FIELD_BYTES);
				default: len = 9'($urandom_range(ffb_pkg::DATA_FIELD_BYTES, 0));
			endcase
		end else begin
			len = 9'($urandom_range(511, 0));
		end
		send_tick(8'($urandom_range(255, 0)), len);
	endtask

	// Drop valid and wait until every expected byte has come back.
	task automatic settle();
		pay_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	// Setup phase, access phase, then an idle phase before the bus can be used again.
	task automatic write_register(input logic [ffb_pkg::PADDR_W-1:0] addr,
		input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_COMMAND_ID) begin
			fb_cmd = data[15:0];
		end
		@(posedge clk);
	endtask

	task automatic check_command_id_readback();
		logic [15:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_COMMAND_ID;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata[15:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== fb_cmd) begin
			$error("command_id: expected %04h, got %04h", fb_cmd, got);
			error_count++;
		end
		@(posedge clk);
	endtask

	// Compare one accepted frame byte with the oldest expectation.
	task automatic check_frame_byte();
		frame_byte_t want;
		if (pending_bytes.size() == 0) begin
			$error("frame_byte: expected none, got %02h", frm_if.frame_byte);
			error_count++;
			return;
		end
		want = pending_bytes.pop_front();
		if (frm_if.frame_byte !== want.data_byte) begin
			$error("frame_byte: expected %02h, got %02h", want.data_byte, frm_if.frame_byte);
			error_count++;
		end
		if (frm_if.byte_taken !== want.taken) begin
			$error("byte_taken: expected %0b, got %0b", want.taken, frm_if.byte_taken);
			error_count++;
		end
		if (frm_if.frame_end !== want.frame_last) begin
			$error("frame_end: expected %0b, got %0b", want.frame_last, frm_if.frame_end);
			error_count++;
		end
		if (frm_if.rejected !== want.reject) begin
			$error("rejected: expected %0b, got %0b", want.reject, frm_if.rejected);
			error_count++;
		end
	endtask

	// Receiver: check each accepted byte, then hold ready low for a drawn wait.
	// A hold-off request overrides the normal wait and is counted down here.
	always @(posedge clk) begin
		if (!arst_n) begin
			frm_if.ready <= 1'b0;
		end else begin
			if (frm_if.valid && frm_if.ready) begin
				check_frame_byte();
				sink_wait = sink_idle ? $urandom_range(MAX_IDLE, 0) : 0;
			end
			if (sink_hold_req != 0) begin
				sink_hold = sink_hold_req;
				sink_hold_req = 0;
			end
			if (sink_hold != 0) begin
				sink_hold--;
				frm_if.ready <= 1'b0;
			end else if (sink_wait != 0) begin
				sink_wait--;
				frm_if.ready <= 1'b0;
			end else begin
				frm_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Oversize lengths on the first tick: each is flagged and no frame starts.
	task automatic test_rejects();
		send_tick(8'h00, 9'(ffb_pkg::DATA_FIELD_BYTES + 1));
		send_tick(8'hFF, 9'h1FF);
		send_tick(8'h5A, 9'h100 + 9'(ffb_pkg::DATA_FIELD_BYTES - 255));
		send_tick(8'hA5, 9'h1FE);
		send_tick(8'h00, 9'(ffb_pkg::DATA_FIELD_BYTES + 2));
	endtask

	// Full-length payload, no padding; open with extreme byte values and
	// noisy length fields on the later ticks.
	task automatic test_full_payload();
		for (int i = 0; i < ffb_pkg::FRAME_BYTES; i++) begin
			if (i == 0) begin
				send_tick(8'hFF, 9'(ffb_pkg::DATA_FIELD_BYTES));
			end else if (i < 24) begin
				send_tick((i % 2) ? 8'hFF : 8'h00, (i % 2) ? 9'h1FF : 9'h000);
			end else begin
				send_tick(8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
			end
		end
	endtask

	// Command id extremes, a write to an unmapped slot, and an all-padding frame.
	task automatic test_command_id();
		settle();
		check_command_id_readback();
		write_register(ADDR_COMMAND_ID, 32'hFFFF_0000);
		write_register(ADDR_UNMAPPED, 32'h0000_BEEF);
		check_command_id_readback();
		// zero length: every data byte is padding, nothing taken
		send_tick(8'hFF, 9'd0);
		for (int i = 1; i < ffb_pkg::FRAME_BYTES; i++) begin
			send_tick(8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
		end
		settle();
		write_register(ADDR_COMMAND_ID, 32'h0000_FFFF);
		check_command_id_readback();
	endtask

	// Random ticks in chunks; idling modes and command id change between chunks.
	task automatic test_random_traffic(input int unsigned n_items);
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				src_idle  = ($urandom_range(3, 0) != 0);
				sink_idle = ($urandom_range(3, 0) != 0);
			end
			if (i % 100 == 99) begin
				settle();
				write_register(ADDR_COMMAND_ID, $urandom);
			end
			send_random_tick();
		end
	endtask

	// Receiver holds off for a long stretch while ticks are offered back to
	// back, so the block fills and stalls its input.
	task automatic test_backpressure();
		settle();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		sink_hold_req = 120;
		for (int i = 0; i < 150; i++) begin
			send_random_tick();
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	initial begin
		// known values on every input from time zero
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		pay_if.valid          = 1'b0;
		pay_if.payload_byte   = '0;
		pay_if.payload_length = '0;
		frm_if.ready          = 1'b0;

		fb_pos = 0;
		fb_seq = '0;
		fb_crc = ffb_pkg::CRC16_INIT;
		fb_len = '0;
		fb_cmd = ffb_pkg::CMD_ID_RST;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rejects();
		test_full_payload();
		test_command_id();
		test_random_traffic(300);
		test_backpressure();

		// drain, then idle so that any stray byte from the pipeline shows
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
